@@ design/best_fit_heap_allocator_assert.svh @@
// Assertion macros for the best-fit heap allocator.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BFH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define BFH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/bfha_pkg.sv @@
// Shared types and constants for the best-fit heap allocator.
`default_nettype none
package bfha_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    ST_TABLE = 3'd0,
    ST_GROWN = 3'd1,
    ST_NOOP  = 3'd2,
    ST_FULL  = 3'd3,
    ST_LIMIT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_MERGE,
    S_OUT
  } state_e;

  // Operation that the cell row performs at a clock edge.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_INSERT,
    OP_REMOVE,
    OP_WRITE
  } cell_op_e;

  typedef struct packed {
    logic [DataW-1:0] start;
    logic [DataW-1:0] len;
  } entry_t;
endpackage
`default_nettype wire

@@ design/bfha_cell.sv @@
// One free-table cell: holds an entry and passes it toward cell zero on rotate.
`default_nettype none
module bfha_cell (
  input  logic               clk_i,
  input  bfha_pkg::cell_op_e op_i,
  input  logic               sel_i,
  input  logic               after_i,
  input  bfha_pkg::entry_t   next_i,
  input  bfha_pkg::entry_t   prev_i,
  input  bfha_pkg::entry_t   wr_i,
  output bfha_pkg::entry_t   ent_o
);
  import bfha_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    case (op_i)
      OP_ROTATE: ent_d = next_i;
      OP_INSERT: begin
        if (sel_i) ent_d = wr_i;
        else if (after_i) ent_d = prev_i;
      end
      OP_REMOVE: if (sel_i || after_i) ent_d = next_i;
      OP_WRITE:  if (sel_i) ent_d = wr_i;
      default:   ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
endmodule
`default_nettype wire

@@ design/best_fit_heap_allocator.sv @@
// Top level of the best-fit heap allocator: cell row, scan and merge control.
//
//  channel | direction | handshake     | beat
//  req     | in        | valid / stall | req_type, req_size, free_addr, header_size
//  rsp     | out       | valid / stall | data_addr, block_size, status
//  cfg     | in        | valid / ready | heap_limit
//
// One request at a time. A request scans the row once, one entry per cycle,
// then a decide state that also does the insert, remove or split. A free that
// is inserted then checks for a merge with the entry before it and with the
// entry after it, with a step per merge done that drops the absorbed entry.
// Then the result beat, and a return to idle before the next accept.
// Reset is asynchronous; the table is empty after reset. A stalled result holds
// the block; req_stall_o is high whenever a request is in work.
`default_nettype none
module best_fit_heap_allocator #(
  parameter int unsigned FREE_ENTRIES = 32,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned ADDR_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] free_addr_i,
  input  logic [31:0] header_size_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [31:0] data_addr_o,
  output logic [31:0] block_size_o,
  output logic [bfha_pkg::StatusW-1:0] status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] heap_limit_i
);
  import bfha_pkg::*;
  `include "best_fit_heap_allocator_assert.svh"

  localparam int unsigned IW = $clog2(FREE_ENTRIES);
  localparam int unsigned CW = $clog2(FREE_ENTRIES + 1);
  localparam logic [63:0] CAP64 = (ADDR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                  ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [33:0] HDR = 34'(HEADER_BYTES);
  localparam logic [CW-1:0] NENT = CW'(FREE_ENTRIES);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0] top_q, top_d, limit_q;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] best_q, best_d, pos_q, pos_d;
  logic found_q, found_d, exact_q, exact_d;
  logic [31:0] best_len_q, best_len_d;
  logic [31:0] best_start_q, best_start_d;
  logic prev_ok_q, prev_ok_d;
  logic req_type_q;
  logic [31:0] size_q, addr_q, hsz_q;
  logic [31:0] out_addr_q, out_addr_d, out_size_q, out_size_d;
  logic [StatusW-1:0] out_st_q, out_st_d;
  logic [1:0] step_q, step_d;

  cell_op_e op;
  logic [IW-1:0] sel;
  entry_t wr;
  entry_t ent [FREE_ENTRIES];

  for (genvar g = 0; g < FREE_ENTRIES; g++) begin : g_cell
    bfha_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .sel_i  (sel == IW'(g)),
      .after_i(IW'(g) > sel),
      .next_i (ent[(g + 1) % FREE_ENTRIES]),
      .prev_i (ent[(g + FREE_ENTRIES - 1) % FREE_ENTRIES]),
      .wr_i   (wr),
      .ent_o  (ent[g])
    );
  end

  // Cell zero is the scan head; a full rotation restores order.
  entry_t head;
  assign head = ent[0];
  logic in_tab;
  assign in_tab = scan_q < cnt_q;

  logic [33:0] need, end_top, m_end, m_sum, split_st;
  logic [63:0] limit64;
  entry_t ea, eb;
  assign need = {2'b0, size_q} + HDR;
  assign end_top = {2'b0, top_q} + need;
  assign limit64 = ({32'b0, limit_q} > CAP64) ? CAP64 : {32'b0, limit_q};
  assign split_st = {2'b0, best_start_q} + need;

  always_comb begin
    ea = ent[sel];
    eb = ent[(sel == IW'(FREE_ENTRIES - 1)) ? '0 : sel + IW'(1)];
    m_end = {2'b0, ea.start} + HDR + {2'b0, ea.len};
    m_sum = {2'b0, ea.len} + HDR + {2'b0, eb.len};
  end

  logic merge_ok;
  assign merge_ok = (m_end == {2'b0, eb.start}) && (m_sum[33:32] == 2'b0);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; top_d = top_q; scan_d = scan_q;
    best_d = best_q; pos_d = pos_q; found_d = found_q; exact_d = exact_q;
    best_len_d = best_len_q; best_start_d = best_start_q;
    prev_ok_d = prev_ok_q;
    out_addr_d = out_addr_q; out_size_d = out_size_q; out_st_d = out_st_q;
    step_d = step_q;
    op = OP_HOLD; sel = '0; wr = '0;
    case (state_q)
      S_IDLE: begin
        scan_d = '0; found_d = 1'b0; exact_d = 1'b0; pos_d = cnt_q;
        prev_ok_d = 1'b0;
      end
      S_SCAN: begin
        op = OP_ROTATE;
        if (in_tab) begin
          if (!req_type_q) begin
            if (!exact_q && head.len == size_q) begin
              exact_d = 1'b1; found_d = 1'b1; best_d = scan_q;
              best_len_d = head.len; best_start_d = head.start;
            end else if (!exact_q && head.len > size_q &&
                         (!found_q || head.len < best_len_q)) begin
              found_d = 1'b1; best_d = scan_q;
              best_len_d = head.len; best_start_d = head.start;
            end
          end else if (pos_q == cnt_q && head.start >= addr_q - 32'(HEADER_BYTES)) begin
            pos_d = scan_q;
          end
        end
        scan_d = scan_q + CW'(1);
        if (scan_q == NENT - CW'(1)) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_OUT;
        out_addr_d = '0; out_size_d = '0;
        if (!req_type_q) begin
          if (size_q == '0) out_st_d = ST_NOOP;
          else if (found_q) begin
            out_st_d = ST_TABLE;
            out_addr_d = best_start_q + 32'(HEADER_BYTES);
            sel = best_q[IW-1:0];
            if ({2'b0, best_len_q} > need) begin
              op = OP_WRITE;
              wr.start = split_st[31:0];
              wr.len = best_len_q - need[31:0];
              out_size_d = size_q;
            end else begin
              op = OP_REMOVE;
              cnt_d = cnt_q - CW'(1);
              out_size_d = best_len_q;
            end
          end else if ({30'b0, end_top} > limit64) out_st_d = ST_LIMIT;
          else begin
            out_st_d = ST_GROWN;
            out_addr_d = top_q + 32'(HEADER_BYTES);
            out_size_d = size_q;
            top_d = end_top[31:0];
          end
        end else begin
          if (addr_q < 32'(HEADER_BYTES)) out_st_d = ST_NOOP;
          else if (cnt_q == NENT) out_st_d = ST_FULL;
          else begin
            out_st_d = ST_TABLE;
            op = OP_INSERT;
            sel = pos_q[IW-1:0];
            wr.start = addr_q - 32'(HEADER_BYTES);
            wr.len = hsz_q;
            cnt_d = cnt_q + CW'(1);
            state_d = S_MERGE;
            step_d = 2'd0;
          end
        end
      end
      S_MERGE: begin
        // step 0: merge pos-1 with pos; step 1: merge cur with cur+1
        if (step_q == 2'd0) begin
          step_d = 2'd1;
          if (pos_q != '0) begin
            sel = IW'(pos_q - CW'(1));
            if (merge_ok) begin
              op = OP_WRITE; wr.start = ea.start; wr.len = m_sum[31:0];
              pos_d = pos_q - CW'(1);
              prev_ok_d = 1'b1;
            end
          end
        end else if (step_q == 2'd1 && prev_ok_q) begin
          // drop the absorbed entry
          sel = IW'(pos_q + CW'(1));
          op = OP_REMOVE;
          cnt_d = cnt_q - CW'(1);
          prev_ok_d = 1'b0;
        end else if (step_q == 2'd1) begin
          step_d = 2'd2;
          sel = pos_q[IW-1:0];
          if (pos_q + CW'(1) < cnt_q && merge_ok) begin
            op = OP_WRITE; wr.start = ea.start; wr.len = m_sum[31:0];
            prev_ok_d = 1'b1;
          end else state_d = S_OUT;
        end else begin
          sel = IW'(pos_q + CW'(1));
          op = OP_REMOVE;
          cnt_d = cnt_q - CW'(1);
          prev_ok_d = 1'b0;
          state_d = S_OUT;
        end
      end
      S_OUT: if (!rsp_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE && req_valid_i) state_d = S_SCAN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; top_q <= '0; limit_q <= 32'd1048576;
      step_q <= '0; prev_ok_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; top_q <= top_d; step_q <= step_d;
      prev_ok_q <= prev_ok_d;
      if (cfg_valid_i) limit_q <= heap_limit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d; best_q <= best_d; pos_q <= pos_d; found_q <= found_d;
    exact_q <= exact_d; best_len_q <= best_len_d; best_start_q <= best_start_d;
    out_addr_q <= out_addr_d; out_size_q <= out_size_d;
    out_st_q <= out_st_d;
    if (state_q == S_IDLE && req_valid_i) begin
      req_type_q <= req_type_i; size_q <= req_size_i;
      addr_q <= free_addr_i; hsz_q <= header_size_i;
    end
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_OUT);
  assign data_addr_o = out_addr_q;
  assign block_size_o = out_size_q;
  assign status_o = out_st_q;
  assign cfg_ready_o = 1'b1;

  `BFH_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= NENT)
  `BFH_ASSERT_NXT(a_acc_scan, clk_i, rst_ni, state_q == S_IDLE && req_valid_i, state_q == S_SCAN)
  `BFH_ASSERT_IMP(a_out_hold, clk_i, rst_ni, rsp_valid_o && rsp_stall_i, ##1 rsp_valid_o)
endmodule
`default_nettype wire
